### src/gbc_pkg.sv
// Package for the GPIO bank controller: constants, address map, field types.
// No dependencies.
package gbc_pkg;

  localparam int unsigned NumBanksDef    = 5;
  localparam int unsigned PinsPerBank    = 32;
  localparam int unsigned ControlAddrDef = 1020;
  localparam int unsigned BankStride     = 12;
  localparam int unsigned PdBase         = 'h208;
  localparam int unsigned MaskBase       = 'h20c;
  localparam int unsigned TypeBase       = 'h230;
  localparam int unsigned CtrlBits       = 25;
  localparam int unsigned MaxBanks       = 5;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_SAMPLE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    TRIG_HIGH    = 2'd0,
    TRIG_LOW     = 2'd1,
    TRIG_RISE    = 2'd2,
    TRIG_FALL    = 2'd3
  } trig_e;

  function automatic logic pin_hit(logic [1:0] t, logic l, logic n);
    logic h;
    case (trig_e'(t))
      TRIG_HIGH: h = n;
      TRIG_LOW:  h = ~n;
      TRIG_RISE: h = ~l & n;
      TRIG_FALL: h = l & ~n;
      default:   h = 1'b0;
    endcase
    return h;
  endfunction

endpackage

### src/gbc_lane.sv
// One bank lane: holds the bank's registers and evaluates its 32 pins in parallel.
// Depends on gbc_pkg.
module gbc_lane (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_oe_i,
  input  logic        wr_ie_i,
  input  logic        wr_data_i,
  input  logic        wr_pd_i,
  input  logic        wr_mask_i,
  input  logic        wr_thi_i,
  input  logic        wr_tlo_i,
  input  logic        sample_i,
  input  logic [31:0] wdata_i,
  input  logic [31:0] levels_i,
  output logic [31:0] oe_o,
  output logic [31:0] ie_o,
  output logic [31:0] data_o,
  output logic [31:0] data_rd_o,
  output logic [31:0] pd_o,
  output logic [31:0] mask_o,
  output logic [63:0] type_o,
  output logic        irq_src_o
);
  import gbc_pkg::*;

  logic [31:0] oe_q, ie_q, data_q, pd_q, pd_d, mask_q, last_q, hit;
  logic [63:0] type_q;

  always_comb begin
    for (int p = 0; p < PinsPerBank; p++) begin
      hit[p] = pin_hit(type_q[2*p +: 2], last_q[p], levels_i[p]);
    end
    pd_d = pd_q;
    if (wr_pd_i) pd_d = pd_q & ~wdata_i;
    if (sample_i) pd_d = pd_q | hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oe_q <= '0; ie_q <= '0; data_q <= '0; pd_q <= '0;
      mask_q <= '0; last_q <= '0; type_q <= '0;
    end else begin
      pd_q <= pd_d;
      if (wr_oe_i) oe_q <= wdata_i;
      if (wr_ie_i) ie_q <= wdata_i;
      if (wr_data_i) data_q <= wdata_i;
      if (wr_mask_i) mask_q <= wdata_i;
      if (wr_thi_i) type_q[63:32] <= wdata_i;
      if (wr_tlo_i) type_q[31:0] <= wdata_i;
      if (sample_i) last_q <= levels_i;
    end
  end

  assign oe_o      = oe_q;
  assign ie_o      = ie_q;
  assign data_o    = data_q;
  assign data_rd_o = (data_q & ~ie_q) | (last_q & ie_q);
  assign pd_o      = pd_q;
  assign mask_o    = mask_q;
  assign type_o    = type_q;
  assign irq_src_o = |(pd_d & (wr_mask_i ? wdata_i : mask_q));
endmodule

### src/gpio_bank_controller_with_irq_top.sv
// GPIO bank controller with per-pin edge/level interrupts: top level.
// Depends on gbc_pkg and gbc_lane.
// Takes one transfer per clock unless the output stalls (bus read, bus write, pin
// sample or no-op) and returns one result per transfer through an output register;
// each bank is a lane that evaluates all its pins in parallel, and a merge stage
// selects read data, drive words and updates the shared control word.
module gpio_bank_controller_with_irq_top #(
  parameter int unsigned NUM_BANKS    = gbc_pkg::NumBanksDef,
  parameter int unsigned CONTROL_ADDR = gbc_pkg::ControlAddrDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser,
  // reg_addr[9:0], write_data[41:10], sample_bank[44:42], pin_levels[76:45]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[31:0], bank_irq[36:32], drive_value[68:37], drive_enable[100:69]
  output logic [103:0] m_axis_tdata
);
  import gbc_pkg::*;

  logic [1:0]  func;
  logic [9:0]  addr;
  logic [31:0] wd, lv;
  logic [2:0]  sb;
  assign func = s_axis_tuser;
  assign addr = s_axis_tdata[9:0];
  assign wd   = s_axis_tdata[41:10];
  assign sb   = s_axis_tdata[44:42];
  assign lv   = s_axis_tdata[76:45];

  logic acc, vld_q;
  assign s_axis_tready = ~vld_q | m_axis_tready;
  assign acc = s_axis_tvalid & s_axis_tready;
  logic is_rd, is_wr;
  assign is_rd = acc && func_e'(func) == FUNC_READ;
  assign is_wr = acc && func_e'(func) == FUNC_WRITE;

  logic [NUM_BANKS-1:0] w_oe, w_ie, w_dt, w_pd, w_mk, w_th, w_tl, smp, src;
  logic [NUM_BANKS-1:0] s_oe, s_ie, s_dt, s_pd, s_mk, s_th, s_tl;
  logic [31:0] oe [NUM_BANKS], ie [NUM_BANKS], dt [NUM_BANKS], drd [NUM_BANKS];
  logic [31:0] pd [NUM_BANKS], mk [NUM_BANKS];
  logic [63:0] ty [NUM_BANKS];
  logic aligned, is_ctrl;
  assign aligned = addr[1:0] == 2'b00;
  assign is_ctrl = aligned && addr == 10'(CONTROL_ADDR);

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      s_oe[b] = aligned && !is_ctrl && addr == 10'(b*BankStride);
      s_ie[b] = aligned && !is_ctrl && addr == 10'(b*BankStride + 4);
      s_dt[b] = aligned && !is_ctrl && addr == 10'(b*BankStride + 8);
      s_pd[b] = aligned && !is_ctrl && addr == 10'(PdBase + b*8);
      s_mk[b] = aligned && !is_ctrl && addr == 10'(MaskBase + b*8);
      s_th[b] = aligned && !is_ctrl && addr == 10'(TypeBase + b*8);
      s_tl[b] = aligned && !is_ctrl && addr == 10'(TypeBase + b*8 + 4);
      smp[b]  = acc && func_e'(func) == FUNC_SAMPLE && sb == 3'(b);
    end
    w_oe = s_oe & {NUM_BANKS{is_wr}};
    w_ie = s_ie & {NUM_BANKS{is_wr}};
    w_dt = s_dt & {NUM_BANKS{is_wr}};
    w_pd = s_pd & {NUM_BANKS{is_wr}};
    w_mk = s_mk & {NUM_BANKS{is_wr}};
    w_th = s_th & {NUM_BANKS{is_wr}};
    w_tl = s_tl & {NUM_BANKS{is_wr}};
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_lane
    gbc_lane u_lane (
      .clk_i, .rst_ni,
      .wr_oe_i(w_oe[b]), .wr_ie_i(w_ie[b]), .wr_data_i(w_dt[b]), .wr_pd_i(w_pd[b]),
      .wr_mask_i(w_mk[b]), .wr_thi_i(w_th[b]), .wr_tlo_i(w_tl[b]), .sample_i(smp[b]),
      .wdata_i(wd), .levels_i(lv),
      .oe_o(oe[b]), .ie_o(ie[b]), .data_o(dt[b]), .data_rd_o(drd[b]), .pd_o(pd[b]),
      .mask_o(mk[b]), .type_o(ty[b]), .irq_src_o(src[b])
    );
  end

  logic [CtrlBits-1:0] ctrl_q, ctrl_d, pmask;
  logic [31:0] rd, dv, de;
  logic [4:0]  irq;

  always_comb begin
    pmask = '0;
    for (int b = 0; b < MaxBanks; b++) pmask[b*5] = 1'b1;
    rd = '0; dv = '0; de = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (s_oe[b]) rd = rd | oe[b];
      if (s_ie[b]) rd = rd | ie[b];
      if (s_dt[b]) rd = rd | drd[b];
      if (s_pd[b]) rd = rd | pd[b];
      if (s_mk[b]) rd = rd | mk[b];
      if (s_th[b]) rd = rd | ty[b][63:32];
      if (s_tl[b]) rd = rd | ty[b][31:0];
      if (smp[b]) begin
        dv = dt[b];
        de = oe[b];
      end
    end
    if (is_ctrl) rd = 32'(ctrl_q);
    if (!is_rd) rd = '0;
    ctrl_d = ctrl_q;
    if (is_wr && is_ctrl)
      ctrl_d = (ctrl_q & pmask & ~wd[CtrlBits-1:0]) | (wd[CtrlBits-1:0] & ~pmask);
    if (acc) begin
      for (int b = 0; b < NUM_BANKS; b++) if (src[b]) ctrl_d[b*5] = 1'b1;
    end
    for (int b = 0; b < MaxBanks; b++) irq[b] = ctrl_d[b*5] & ctrl_d[b*5+1];
  end

  logic [103:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
      if (s_axis_tready) vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) out_q <= {3'b0, de, dv, irq, rd};
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = out_q;
endmodule
